>>> sv/ptsd_pkg.sv
// Shared types, widths and register codes for the PID-to-servo-duty block.
package ptsd_pkg;

  // Defaults for the top-level parameters.
  localparam int ERROR_BITS_DEF     = 13;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Fixed field widths.
  localparam int GAIN_W    = 24;
  localparam int LIMIT_W   = 15;
  localparam int PWM_W     = 16;
  localparam int CTL_W     = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Duty divider: a 16-bit quotient, two bits per cycle.
  localparam int QUO_BITS       = 16;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = QUO_BITS / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PID_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEIL  = 3'd7;

  // Register values after reset.
  localparam logic [GAIN_W-1:0]  RST_GAIN_P     = 24'd655;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I     = 24'd45875;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D     = 24'd45875;
  localparam logic [LIMIT_W-1:0] RST_PID_LIMIT  = 15'd1000;
  localparam logic [PWM_W-1:0]   RST_PWM_MIN    = 16'd1200;
  localparam logic [PWM_W-1:0]   RST_PWM_MAX    = 16'd2400;
  localparam logic [PWM_W-1:0]   RST_DUTY_FLOOR = 16'd1200;
  localparam logic [PWM_W-1:0]   RST_DUTY_CEIL  = 16'd2400;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] pid_limit;
    logic [PWM_W-1:0]   pwm_min;
    logic [PWM_W-1:0]   pwm_max;
    logic [PWM_W-1:0]   duty_floor;
    logic [PWM_W-1:0]   duty_ceil;
  } cfg_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  // What the accumulator does with the registered product.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD,
    ACC_ADD2,
    ACC_ADD_SHR
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     clamp_load;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } cmd_t;

endpackage

>>> sv/ptsd_regs.sv
// Configuration register file of the PID-to-servo-duty block.
module ptsd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ptsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptsd_pkg::CFG_W-1:0]      cfg_data,
  output ptsd_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p     <= ptsd_pkg::RST_GAIN_P;
      cfg.gain_i     <= ptsd_pkg::RST_GAIN_I;
      cfg.gain_d     <= ptsd_pkg::RST_GAIN_D;
      cfg.pid_limit  <= ptsd_pkg::RST_PID_LIMIT;
      cfg.pwm_min    <= ptsd_pkg::RST_PWM_MIN;
      cfg.pwm_max    <= ptsd_pkg::RST_PWM_MAX;
      cfg.duty_floor <= ptsd_pkg::RST_DUTY_FLOOR;
      cfg.duty_ceil  <= ptsd_pkg::RST_DUTY_CEIL;
    end else if (cfg_we) begin
      // Bits above a register's width are dropped.
      case (cfg_index)
        ptsd_pkg::REG_GAIN_P:     cfg.gain_p     <= cfg_data[ptsd_pkg::GAIN_W-1:0];
        ptsd_pkg::REG_GAIN_I:     cfg.gain_i     <= cfg_data[ptsd_pkg::GAIN_W-1:0];
        ptsd_pkg::REG_GAIN_D:     cfg.gain_d     <= cfg_data[ptsd_pkg::GAIN_W-1:0];
        ptsd_pkg::REG_PID_LIMIT:  cfg.pid_limit  <= cfg_data[ptsd_pkg::LIMIT_W-1:0];
        ptsd_pkg::REG_PWM_MIN:    cfg.pwm_min    <= cfg_data[ptsd_pkg::PWM_W-1:0];
        ptsd_pkg::REG_PWM_MAX:    cfg.pwm_max    <= cfg_data[ptsd_pkg::PWM_W-1:0];
        ptsd_pkg::REG_DUTY_FLOOR: cfg.duty_floor <= cfg_data[ptsd_pkg::PWM_W-1:0];
        ptsd_pkg::REG_DUTY_CEIL:  cfg.duty_ceil  <= cfg_data[ptsd_pkg::PWM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/ptsd_ctrl.sv
// Sequencing state machine of the PID-to-servo-duty block.
module ptsd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output ptsd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC_D,
    S_CLAMP,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC_HI,
    S_DIV_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t                          state;
  logic [ptsd_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic                            out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = ptsd_pkg::MUL_P;
    cmd.acc_op     = ptsd_pkg::ACC_HOLD;
    case (state)
      S_IDLE:     cmd.capture = in_valid;
      S_MUL_P: begin
        cmd.mul_sel = ptsd_pkg::MUL_P;
        cmd.acc_op  = ptsd_pkg::ACC_CLR;
      end
      S_MUL_I: begin
        cmd.mul_sel = ptsd_pkg::MUL_I;
        cmd.acc_op  = ptsd_pkg::ACC_ADD2;
      end
      S_MUL_D: begin
        cmd.mul_sel = ptsd_pkg::MUL_D;
        cmd.acc_op  = ptsd_pkg::ACC_ADD;
      end
      S_ACC_D:    cmd.acc_op = ptsd_pkg::ACC_ADD2;
      S_CLAMP:    cmd.clamp_load = 1'b1;
      S_MUL_LO: begin
        cmd.mul_sel  = ptsd_pkg::MUL_LO;
        cmd.acc_op   = ptsd_pkg::ACC_CLR;
      end
      S_MUL_HI: begin
        cmd.mul_sel = ptsd_pkg::MUL_HI;
        cmd.acc_op  = ptsd_pkg::ACC_ADD_SHR;
      end
      S_ACC_HI:   cmd.acc_op = ptsd_pkg::ACC_ADD;
      S_DIV_PREP: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_FIN:      cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:     if (in_valid) state <= S_MUL_P;
        S_MUL_P:    state <= S_MUL_I;
        S_MUL_I:    state <= S_MUL_D;
        S_MUL_D:    state <= S_ACC_D;
        S_ACC_D:    state <= S_CLAMP;
        S_CLAMP:    state <= S_MUL_LO;
        S_MUL_LO:   state <= S_MUL_HI;
        S_MUL_HI:   state <= S_ACC_HI;
        S_ACC_HI:   state <= S_DIV_PREP;
        S_DIV_PREP: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == ptsd_pkg::DIV_CNT_W'(ptsd_pkg::DIV_STEPS - 1)) begin
            state <= S_FIN;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ptsd_dp.sv
// Datapath of the PID-to-servo-duty block: shared multiplier, accumulator,
// clamp, duty divider and output registers.
module ptsd_dp #(
  parameter int ERROR_BITS     = ptsd_pkg::ERROR_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ptsd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ptsd_pkg::cfg_t                      cfg,
  input  ptsd_pkg::cmd_t                      cmd,
  input  logic signed [ERROR_BITS-1:0]        height_error,
  output logic        [ptsd_pkg::PWM_W-1:0]   servo_duty,
  output logic signed [ptsd_pkg::CTL_W-1:0]   clamped_control
);

  localparam int F   = GAIN_FRAC_BITS;
  localparam int LW  = ptsd_pkg::LIMIT_W;
  localparam int QB  = ptsd_pkg::QUO_BITS;
  localparam int MA  = (ptsd_pkg::GAIN_W + 1 > F + 3) ? ptsd_pkg::GAIN_W + 1 : F + 3;
  localparam int MB  = (ERROR_BITS + 1 > ptsd_pkg::PWM_W + 1) ?
                       ERROR_BITS + 1 : ptsd_pkg::PWM_W + 1;
  localparam int PW  = MA + MB;
  localparam int AW  = ERROR_BITS + ptsd_pkg::GAIN_W + 4;
  localparam int WW  = F + LW + 2;
  localparam int LSW = WW + 1;
  localparam int VW  = ((AW > LSW) ? AW : LSW) + 1;
  localparam int SH  = F + 2;
  localparam int DW  = ptsd_pkg::PWM_W + 2;

  logic signed [ERROR_BITS-1:0]   e_cur;
  logic signed [ERROR_BITS-1:0]   last_error;
  logic signed [ERROR_BITS:0]     e_sum;
  logic signed [ERROR_BITS:0]     e_diff;
  logic signed [ptsd_pkg::PWM_W:0] span;
  logic signed [MA-1:0]           mul_a;
  logic signed [MB-1:0]           mul_b;
  logic signed [PW-1:0]           prod;
  logic signed [AW-1:0]           acc;
  logic signed [VW-1:0]           lim;
  logic signed [VW-1:0]           lim2;
  logic signed [VW-1:0]           t_off;
  logic        [WW-1:0]           w;
  logic        [WW-1:0]           w_next;
  logic signed [VW-1:0]           v_cl;
  logic signed [VW-1:0]           v_fl;
  logic signed [ptsd_pkg::CTL_W-1:0] ctl;
  logic signed [AW-1:0]           mag;
  logic                           neg;
  logic        [LW-1:0]           rem;
  logic        [QB-1:0]           quo;
  logic        [LW-1:0]           rem_next;
  logic        [QB-1:0]           quo_next;
  logic signed [DW-1:0]           quo_s;
  logic signed [DW-1:0]           duty_q;
  logic signed [DW-1:0]           duty_s;
  logic        [ptsd_pkg::PWM_W-1:0] duty;

  assign e_sum  = (ERROR_BITS + 1)'(e_cur) + (ERROR_BITS + 1)'(last_error);
  assign e_diff = (ERROR_BITS + 1)'(e_cur) - (ERROR_BITS + 1)'(last_error);
  assign span   = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      ptsd_pkg::MUL_P: begin
        mul_a = MA'($signed({1'b0, cfg.gain_p}));
        mul_b = MB'(e_cur);
      end
      ptsd_pkg::MUL_I: begin
        mul_a = MA'($signed({1'b0, cfg.gain_i}));
        mul_b = MB'(e_sum);
      end
      ptsd_pkg::MUL_D: begin
        mul_a = MA'($signed({1'b0, cfg.gain_d}));
        mul_b = MB'(e_diff);
      end
      ptsd_pkg::MUL_LO: begin
        mul_a = MA'($signed({1'b0, w[SH-1:0]}));
        mul_b = MB'(span);
      end
      ptsd_pkg::MUL_HI: begin
        mul_a = MA'($signed({1'b0, w[WW-1:SH]}));
        mul_b = MB'(span);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The clamp works on w = v + lim, which must land in [0, 2*lim].
  assign lim   = VW'($signed({1'b0, cfg.pid_limit})) <<< (F + 1);
  assign lim2  = lim <<< 1;
  assign t_off = lim - VW'(acc);

  always_comb begin
    if (t_off < 0) begin
      w_next = '0;
    end else if (t_off > lim2) begin
      w_next = lim2[WW-1:0];
    end else begin
      w_next = t_off[WW-1:0];
    end
  end

  // Integer part of the clamped signal, truncated toward zero.
  assign v_cl = VW'($signed({1'b0, w})) - lim;
  assign v_fl = v_cl >>> (F + 1);
  assign ctl  = ptsd_pkg::CTL_W'(v_fl +
                VW'($signed({1'b0, (v_cl < 0) && (|v_cl[F:0])})));

  assign neg = acc[AW-1];
  assign mag = neg ? -acc : acc;

  // Two restoring divide steps per cycle.
  always_comb begin
    logic [LW:0] trial;
    logic        qbit;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < ptsd_pkg::DIV_RADIX_BITS; i++) begin
      trial = {rem_next, quo_next[QB-1]};
      qbit  = (trial >= {1'b0, cfg.pid_limit});
      if (qbit) begin
        rem_next = LW'(trial - {1'b0, cfg.pid_limit});
      end else begin
        rem_next = trial[LW-1:0];
      end
      quo_next = {quo_next[QB-2:0], qbit};
    end
  end

  // Floor of the signed quotient, then offset and duty clamp.
  assign quo_s = $signed({2'b00, quo});

  always_comb begin
    if (!neg) begin
      duty_q = quo_s;
    end else if (rem != '0) begin
      duty_q = ~quo_s;
    end else begin
      duty_q = -quo_s;
    end
    if (cfg.pid_limit == '0) begin
      duty_s = $signed({2'b00, cfg.pwm_min});
    end else begin
      duty_s = duty_q + $signed({2'b00, cfg.pwm_min});
    end
    if (duty_s > $signed({2'b00, cfg.duty_ceil})) begin
      duty = cfg.duty_ceil;
    end else if (duty_s < $signed({2'b00, cfg.duty_floor})) begin
      duty = cfg.duty_floor;
    end else begin
      duty = duty_s[ptsd_pkg::PWM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
    end else if (cmd.out_load) begin
      last_error <= e_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      e_cur <= height_error;
    end
    prod <= mul_a * mul_b;
    case (cmd.acc_op)
      ptsd_pkg::ACC_CLR:     acc <= '0;
      ptsd_pkg::ACC_ADD:     acc <= acc + AW'(prod);
      ptsd_pkg::ACC_ADD2:    acc <= acc + (AW'(prod) <<< 1);
      ptsd_pkg::ACC_ADD_SHR: acc <= acc + AW'(prod >>> SH);
      default: ;
    endcase
    if (cmd.clamp_load) begin
      w <= w_next;
    end
    if (cmd.div_init) begin
      rem <= mag[QB+LW-1:QB];
      quo <= mag[QB-1:0];
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    // Both result fields change only when a new beat is loaded, so a
    // stalled beat holds still.
    if (cmd.out_load) begin
      servo_duty      <= duty;
      clamped_control <= ctl;
    end
  end

endmodule

>>> sv/pid_to_servo_duty.sv
// Top level of the PID-to-servo-duty block: registers, controller and datapath.
//
// The block turns a stream of signed height error samples into servo duty
// values. Each input beat carries one error sample on height_error; each
// output beat carries the clamped integer duty on servo_duty and the integer
// part of the inverted, clamped control signal on clamped_control.
// Both channels move a beat at a rising edge where valid is high and stall is
// low. The block takes one sample at a time: in_stall is low only while the
// sequencer is idle and out of reset. Each sample is worked through the
// single shared multiplier (five products, each followed by an accumulate)
// and the duty divider, which resolves two quotient bits per cycle.
// A finished result sits in the output register; if the receiver stalls,
// the next sample is still accepted and computed, and the sequencer holds
// it in its final step until the output register is free.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at the
// next edge and should be made only while the block is idle.
// Synchronous reset restores the default gains and limits, clears the stored
// previous error to zero and empties the output register.
module pid_to_servo_duty #(
  parameter int ERROR_BITS     = ptsd_pkg::ERROR_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ptsd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ERROR_BITS-1:0]       height_error,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [ptsd_pkg::PWM_W-1:0]  servo_duty,
  output logic signed [ptsd_pkg::CTL_W-1:0]  clamped_control,
  input  logic                               cfg_we,
  input  logic [ptsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptsd_pkg::CFG_W-1:0]         cfg_data
);

  ptsd_pkg::cfg_t cfg;
  ptsd_pkg::cmd_t cmd;

  // Gains, limits and the duty map, all software-written.
  ptsd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The sequencer steps one sample through the datapath and owns the
  // handshakes on both channels.
  ptsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The PID sum is built exactly in fixed point, scaled by two to the power of
  // the gain fraction bits plus one, so the halving of the error average is
  // exact. Only the final duty is floored.
  ptsd_dp #(
    .ERROR_BITS     (ERROR_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .height_error    (height_error),
    .servo_duty      (servo_duty),
    .clamped_control (clamped_control)
  );

endmodule
